FILE: hw/rtl/itag_pkg.sv
// ----------------------------------------------------------------------------
// Image transpose address generator package
// Shared widths, register indexes and the dimension clamp function.
// ----------------------------------------------------------------------------
package itag_pkg;

  localparam int unsigned CFG_W     = 13;   // width of the configuration registers
  localparam int unsigned CFG_IDX_W = 4;    // width of the register index
  localparam int unsigned ADDR_W    = 24;   // write address width
  localparam int unsigned PIX_W     = 32;   // pixel word width on the ports

  localparam int unsigned DEF_MAX_DIM    = 4096;
  localparam int unsigned DEF_PIXEL_BITS = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT   = 4'd0,
    REG_COL_COUNT   = 4'd1,
    REG_OUT_PITCH   = 4'd2,
    REG_ORIGIN_LL   = 4'd3
  } cfg_reg_e;

  // A zero count behaves as one, and counts above the maximum are clamped.
  function automatic int unsigned eff_count(logic [CFG_W-1:0] v, int unsigned max_dim);
    int unsigned r;
    r = 32'(v);
    if (r == 0) begin
      r = 1;
    end else if (r > max_dim) begin
      r = max_dim;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/image_transpose_address_gen.sv
// ----------------------------------------------------------------------------
// Image transpose address generator
// Pairs each incoming pixel with its offset in the transposed output frame.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels of the active image arrive in raster order on the s_axis channel,
//   one word each. Every accepted word leaves on the m_axis channel with its
//   write address in tdata and tlast high on the final pixel of the frame.
//   Frame geometry (rows, columns, output pitch, origin mode) is written on
//   the cfg channel, which is always ready; write it only while the block is
//   empty. The row and column counters are not touched by configuration.
//   A word passes one input register and one result register, in that order,
//   and shows on m_axis from the result register. Throughput is one pixel
//   per cycle while m_axis_tready_i stays high; the address multiply-add
//   sits alone between the two registers.
//   When the receiver stalls, the result register holds its word, the input
//   register fills behind it, and then s_axis_tready_o drops; no word is lost.
//   Reset sets all counts and the pitch to 1, selects lower-left origin,
//   clears the counters and empties both registers.
module image_transpose_address_gen #(
  parameter int unsigned MAX_DIM    = itag_pkg::DEF_MAX_DIM,
  parameter int unsigned PIXEL_BITS = itag_pkg::DEF_PIXEL_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // cfg channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [itag_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [itag_pkg::CFG_W-1:0]     cfg_data_i,
  // pixel input
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [itag_pkg::PIX_W-1:0]     s_axis_tdata_i,   // [31:0] pixel_in
  // address output
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [63:0]                    m_axis_tdata_o,   // [23:0] write_address,
                                                           // [55:24] pixel_out, [63:56] zero
  output logic                           m_axis_tlast_o    // frame_last
);
  import itag_pkg::*;

  localparam int unsigned IDX_W  = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_DIM + 1);
  localparam int unsigned KEEP_W = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;

  // Configuration registers
  logic [CFG_W-1:0] row_cfg_q, col_cfg_q, pitch_q;
  logic             origin_ll_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cfg_q   <= CFG_W'(1);
      col_cfg_q   <= CFG_W'(1);
      pitch_q     <= CFG_W'(1);
      origin_ll_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ROW_COUNT: row_cfg_q   <= cfg_data_i;
        REG_COL_COUNT: col_cfg_q   <= cfg_data_i;
        REG_OUT_PITCH: pitch_q     <= cfg_data_i;
        REG_ORIGIN_LL: origin_ll_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] rows, cols;
  assign rows = CNT_W'(eff_count(row_cfg_q, MAX_DIM));
  assign cols = CNT_W'(eff_count(col_cfg_q, MAX_DIM));

  // Handshake and pipeline control
  logic s1_valid_q, out_valid_q;
  logic out_load, s1_load, s_acc;

  assign out_load        = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || out_load;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign s1_load         = s_acc;

  // Row and column counters
  logic [IDX_W-1:0] row_q, row_d, col_q, col_d;
  logic             last_col, last_row;

  assign last_col = CNT_W'(col_q) >= (cols - CNT_W'(1));
  assign last_row = CNT_W'(row_q) >= (rows - CNT_W'(1));

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + IDX_W'(1);
    end else begin
      col_d = col_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (s_acc) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // Transposed coordinates, modulo the address width
  logic [ADDR_W-1:0] ii_d, jj_d;

  always_comb begin
    if (origin_ll_q) begin
      ii_d = ADDR_W'(rows) - ADDR_W'(1) - ADDR_W'(row_q);
      jj_d = ADDR_W'(cols) - ADDR_W'(1) - ADDR_W'(col_q);
    end else begin
      ii_d = ADDR_W'(row_q);
      jj_d = ADDR_W'(col_q);
    end
  end

  // Input register
  logic [ADDR_W-1:0] ii_q, jj_q;
  logic [KEEP_W-1:0] s1_pix_q;
  logic              s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      ii_q      <= ii_d;
      jj_q      <= jj_d;
      s1_pix_q  <= s_axis_tdata_i[KEEP_W-1:0];
      s1_last_q <= last_col && last_row;
    end
  end

  // Address multiply-add and result register
  logic [ADDR_W-1:0] addr_d, addr_q;
  logic [KEEP_W-1:0] out_pix_q;
  logic              out_last_q;

  assign addr_d = ADDR_W'(jj_q * ADDR_W'(pitch_q)) + ii_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      addr_q     <= addr_d;
      out_pix_q  <= s1_pix_q;
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {8'd0, PIX_W'(out_pix_q), addr_q};

  // Assertions
  a_wrap_at_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && last_col && last_row |=> row_q == '0 && col_q == '0)
    else $error("counters did not wrap after the last pixel");

  a_col_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && !last_col |=> col_q == $past(col_q) + IDX_W'(1) && row_q == $past(row_q))
    else $error("column counter did not advance");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> s1_valid_q && out_valid_q && !m_axis_tready_i)
    else $error("input stalled while a register was free");

  a_s1_not_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_load |=> s1_valid_q)
    else $error("input register word lost");

endmodule
